// ===== src/tli_pkg.sv =====
`default_nettype none

package tli_pkg;

  localparam int VAL_W = 24;
  localparam int ENERGY_W = 24;
  localparam int DIV_STEPS = 24;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic signed [VAL_W+1:0] SAT_MAX = 26'sd8388607;
  localparam logic signed [VAL_W+1:0] SAT_MIN = -26'sd8388608;

  // One table entry as it lies in the table memory.
  typedef struct packed {
    logic [ENERGY_W-1:0]    energy;
    logic signed [VAL_W-1:0] fp;
    logic                   fp_defined;
    logic signed [VAL_W-1:0] fdp;
  } entry_t;

  // Operands of one interpolation: a + round((b - a) * num / den).
  typedef struct packed {
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic [ENERGY_W-1:0]    num;
    logic [ENERGY_W-1:0]    den;
  } lerp_req_t;

endpackage

`default_nettype wire

// ===== src/tli_lerp.sv =====
`default_nettype none

module tli_lerp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire tli_pkg::lerp_req_t            req,
  output logic                               done,
  output logic signed [tli_pkg::VAL_W-1:0]   result
);

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_MUL  = 3'd1;
  localparam logic [2:0] L_PREP = 3'd2;
  localparam logic [2:0] L_DIV  = 3'd3;
  localparam logic [2:0] L_FIN  = 3'd4;

  localparam logic [4:0] LAST_STEP = 5'(tli_pkg::DIV_STEPS - 1);

  logic [2:0] state;
  logic [4:0] step;

  logic signed [tli_pkg::VAL_W-1:0] a_r;
  logic signed [tli_pkg::VAL_W:0]   diff;
  logic [tli_pkg::ENERGY_W-1:0]     num_r;
  logic [tli_pkg::ENERGY_W-1:0]     den_r;
  logic signed [49:0]               prod;
  logic                             neg;
  logic [48:0]                      rem;
  logic [47:0]                      dsh;
  logic [tli_pkg::DIV_STEPS-1:0]    quo;

  logic [49:0]              mag;
  logic                     fits;
  logic signed [25:0]       qs;
  logic signed [25:0]       sum;

  always_comb begin
    mag = prod[49] ? 50'(-prod) : 50'(prod);
    fits = rem >= {1'b0, dsh};
    if (den_r == '0) begin
      qs = '0;
    end else if (neg) begin
      qs = -$signed({2'b00, quo});
    end else begin
      qs = $signed({2'b00, quo});
    end
    sum = {{2{a_r[tli_pkg::VAL_W-1]}}, a_r} + qs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (start) begin
            a_r <= req.a;
            diff <= {req.b[tli_pkg::VAL_W-1], req.b} - {req.a[tli_pkg::VAL_W-1], req.a};
            num_r <= req.num;
            den_r <= req.den;
            state <= L_MUL;
          end
        end
        L_MUL: begin
          prod <= diff * $signed({1'b0, num_r});
          state <= L_PREP;
        end
        L_PREP: begin
          // Adding half the divisor before flooring the magnitude rounds
          // ties away from zero once the sign is put back.
          neg <= prod[49];
          rem <= mag[48:0] + {25'd0, 1'b0, den_r[tli_pkg::ENERGY_W-1:1]};
          dsh <= {1'b0, den_r, 23'd0};
          quo <= '0;
          step <= '0;
          state <= L_DIV;
        end
        L_DIV: begin
          if (fits) begin
            rem <= rem - {1'b0, dsh};
          end
          quo <= {quo[tli_pkg::DIV_STEPS-2:0], fits};
          dsh <= {1'b0, dsh[47:1]};
          step <= step + 5'd1;
          if (step == LAST_STEP) begin
            state <= L_FIN;
          end
        end
        L_FIN: begin
          if (sum > tli_pkg::SAT_MAX) begin
            result <= tli_pkg::SAT_MAX[tli_pkg::VAL_W-1:0];
          end else if (sum < tli_pkg::SAT_MIN) begin
            result <= tli_pkg::SAT_MIN[tli_pkg::VAL_W-1:0];
          end else begin
            result <= sum[tli_pkg::VAL_W-1:0];
          end
          done <= 1'b1;
          state <= L_IDLE;
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/table_linear_interpolator_core.sv =====
`default_nettype none

// Piecewise linear table interpolator.
// Input channel (in_valid/in_ready): an item with command 0 loads one table
// entry at entry_index; an item with command 1 queries at the given energy.
// Each query gives exactly one result item on the output channel
// (out_valid/out_ready); a load gives none. entry_count, written through the
// cfg_valid/cfg_ready/cfg_data port, sets how many entries take part in a
// search; the user must write it only while the block is idle, and the
// block itself does not enforce it. A load is written as it is accepted.
// For a query, the search reads the table memory one entry a cycle until it
// finds the bracketing entry; then the shared 24-step divider interpolates
// fdp, and after it fp when fp is defined on both entries. The next item
// can be taken in the same cycle that the result appears.
// A query that falls outside the table completes after the search alone.
// Items are taken one at a time; a finished result waits in the output
// register while loads are still accepted, and a following query holds its
// result until the receiver has taken the previous one.
// Reset clears entry_count and the control state; table contents are
// undefined until loaded.
module table_linear_interpolator_core #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 command,
  input  wire logic [7:0]                           entry_index,
  input  wire logic [tli_pkg::ENERGY_W-1:0]         energy,
  input  wire logic signed [tli_pkg::VAL_W-1:0]     entry_fp,
  input  wire logic                                 entry_fp_defined,
  input  wire logic signed [tli_pkg::VAL_W-1:0]     entry_fdp,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [tli_pkg::VAL_W-1:0]          fp_value,
  output logic                                      fp_valid,
  output logic signed [tli_pkg::VAL_W-1:0]          fdp_value,
  output logic                                      fdp_valid,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [8:0]                           cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [31:0] DEPTH_U = 32'(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;
  localparam logic [2:0] S_START_FDP = 3'd2;
  localparam logic [2:0] S_WAIT_FDP  = 3'd3;
  localparam logic [2:0] S_START_FP  = 3'd4;
  localparam logic [2:0] S_WAIT_FP   = 3'd5;
  localparam logic [2:0] S_DONE      = 3'd6;

  logic [2:0] state;
  logic [8:0] entry_count;

  tli_pkg::entry_t mem [TABLE_DEPTH];
  tli_pkg::entry_t rd_data;
  logic [AW-1:0]   rd_addr;

  logic [AW-1:0]                  cnt;
  logic [AW-1:0]                  n_last;
  logic [tli_pkg::ENERGY_W-1:0]   q_reg;
  tli_pkg::entry_t                prev;
  tli_pkg::entry_t                cur;

  logic signed [tli_pkg::VAL_W-1:0] fp_res;
  logic signed [tli_pkg::VAL_W-1:0] fdp_res;
  logic                             fp_ok;
  logic                             in_range;

  logic [31:0] idx32;
  logic [31:0] n32;
  logic [31:0] n_m1;
  logic        in_acc;
  logic        wr_en;

  logic               lerp_start;
  tli_pkg::lerp_req_t lerp_req;
  logic               lerp_done;
  logic signed [tli_pkg::VAL_W-1:0] lerp_result;

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc = in_valid && in_ready;

  always_comb begin
    idx32 = {24'd0, entry_index};
    n32 = ({23'd0, entry_count} > DEPTH_U) ? DEPTH_U : {23'd0, entry_count};
    n_m1 = n32 - 32'd1;
    wr_en = in_acc && (command == tli_pkg::CMD_LOAD) && (idx32 < DEPTH_U);
    // The search reads one entry ahead, so the entry under test is always
    // in rd_data while the next one is being fetched.
    rd_addr = (state == S_SCAN) ? cnt + {{(AW-1){1'b0}}, 1'b1} : '0;
    lerp_start = (state == S_START_FDP) || (state == S_START_FP);
    lerp_req.num = q_reg - prev.energy;
    lerp_req.den = cur.energy - prev.energy;
    if (state == S_START_FP) begin
      lerp_req.a = prev.fp;
      lerp_req.b = cur.fp;
    end else begin
      lerp_req.a = prev.fdp;
      lerp_req.b = cur.fdp;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx32[AW-1:0]] <= '{energy: energy, fp: entry_fp,
                              fp_defined: entry_fp_defined, fdp: entry_fdp};
    end
    rd_data <= mem[rd_addr];
  end

  tli_lerp u_lerp (
    .clk    (clk),
    .rst    (rst),
    .start  (lerp_start),
    .req    (lerp_req),
    .done   (lerp_done),
    .result (lerp_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      entry_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        entry_count <= cfg_data;
      end
      // In S_DONE the output register is refilled rather than emptied.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && (command != tli_pkg::CMD_LOAD)) begin
            q_reg <= energy;
            n_last <= n_m1[AW-1:0];
            cnt <= '0;
            fp_res <= '0;
            fdp_res <= '0;
            fp_ok <= 1'b0;
            in_range <= 1'b0;
            if (n32 < 32'd2) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cnt == '0) begin
            prev <= rd_data;
            cnt <= cnt + {{(AW-1){1'b0}}, 1'b1};
          end else if (rd_data.energy >= q_reg) begin
            cur <= rd_data;
            // Only the first pair can leave the query below the lower energy.
            if (q_reg >= prev.energy) begin
              in_range <= 1'b1;
              state <= S_START_FDP;
            end else begin
              state <= S_DONE;
            end
          end else if (cnt == n_last) begin
            state <= S_DONE;
          end else begin
            prev <= rd_data;
            cnt <= cnt + {{(AW-1){1'b0}}, 1'b1};
          end
        end
        S_START_FDP: begin
          state <= S_WAIT_FDP;
        end
        S_WAIT_FDP: begin
          if (lerp_done) begin
            fdp_res <= lerp_result;
            if (prev.fp_defined && cur.fp_defined) begin
              state <= S_START_FP;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_START_FP: begin
          state <= S_WAIT_FP;
        end
        S_WAIT_FP: begin
          if (lerp_done) begin
            fp_res <= lerp_result;
            fp_ok <= 1'b1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            fp_value <= fp_res;
            fp_valid <= fp_ok;
            fdp_value <= fdp_res;
            fdp_valid <= in_range;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
